// ===== hw/rtl/zlhw_pkg.sv =====
// zlhw_pkg: shared types and constants of the zip local header walker
// result record, walker push bundle, status codes, signatures, queue sizing
// no dependencies
`default_nettype none

package zlhw_pkg;

  localparam int POS_BITS = 32;

  localparam logic [31:0] SIG_LOCAL   = 32'h04034B50;
  localparam logic [31:0] SIG_CENTRAL = 32'h02014B50;
  localparam logic [31:0] SIG_END     = 32'h06054B50;
  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] ALL_ONES    = 32'hFFFFFFFF;
  localparam logic [15:0] METHOD_STORED  = 16'h0000;
  localparam logic [15:0] METHOD_DEFLATE = 16'h0008;
  localparam logic [4:0]  HEADER_LEN  = 5'd30;
  localparam logic [15:0] NAME_LIMIT_RESET = 16'd32;

  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_END         = 3'd1,
    ST_MALFORMED   = 3'd2,
    ST_UNSUPPORTED = 3'd3,
    ST_CRC         = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] payload_offset;
    logic [31:0] payload_size;
    logic [31:0] uncompressed_size;
    logic        is_deflated;
    logic [31:0] header_crc;
    logic [15:0] name_len;
    logic        name_usable;
    logic        final_result;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } walk_push_t;

endpackage

`default_nettype wire

// ===== hw/rtl/zlhw_crc_byte.sv =====
// zlhw_crc_byte: one byte step of the reflected crc-32
// uses CRC_POLY from zlhw_pkg
`default_nettype none

module zlhw_crc_byte import zlhw_pkg::*; (
  input  logic [31:0] crc,
  input  logic [7:0]  data_byte,
  output logic [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc ^ {24'd0, data_byte};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/zlhw_walker.sv =====
// zlhw_walker: walk state, header capture and verdicts, one byte per step
// depends on zlhw_pkg and zlhw_crc_byte
`default_nettype none

module zlhw_walker import zlhw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [15:0] limit,
  output walk_push_t  push
);

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_NAME    = 5'b00010,
    PH_EXTRA   = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_t;

  localparam logic [4:0] K_FIRST = 5'd0;
  localparam logic [4:0] K_SIG   = 5'd3;
  localparam logic [4:0] K_LAST  = HEADER_LEN - 5'd1;

  phase_t              phase, phase_next;
  logic [POS_BITS-1:0] pos, pos_next;
  logic [4:0]          fbc, fbc_next;
  logic [23:0]         sig_lo, sig_lo_next;
  logic                desc_flag, desc_flag_next;
  logic [15:0]         method, method_next;
  logic [31:0]         hcrc, hcrc_next;
  logic [31:0]         comp, comp_next;
  logic [31:0]         uncomp, uncomp_next;
  logic [15:0]         nlen, nlen_next;
  logic [15:0]         xlen, xlen_next;
  logic [31:0]         left, left_next;
  logic [31:0]         crc, crc_next;
  logic                nhz, nhz_next;
  logic [2:0]          verdict, verdict_next;

  logic [31:0]         crc_upd;
  logic [4:0]          k;
  logic [31:0]         sig;
  logic                adv, adv_name, adv_extra, fin;
  logic [15:0]         xlen_v;
  logic [2:0]          verdict_v, fin_status;
  logic [31:0]         crc_v;
  logic                nhz_v;
  logic                r0, r1, r0_facts;
  logic [2:0]          r0_status;
  logic [POS_BITS-1:0] offset;

  zlhw_crc_byte u_crc (
    .crc       (crc),
    .data_byte (data_byte),
    .crc_out   (crc_upd)
  );

  always_comb begin
    phase_next     = phase;
    pos_next       = pos;
    fbc_next       = fbc;
    sig_lo_next    = sig_lo;
    desc_flag_next = desc_flag;
    method_next    = method;
    hcrc_next      = hcrc;
    comp_next      = comp;
    uncomp_next    = uncomp;
    nlen_next      = nlen;
    xlen_next      = xlen;
    left_next      = left;
    crc_next       = crc;
    nhz_next       = nhz;
    verdict_next   = verdict;
    adv            = 1'b0;
    adv_name       = 1'b0;
    adv_extra      = 1'b0;
    fin            = 1'b0;
    xlen_v         = xlen;
    verdict_v      = verdict;
    fin_status     = verdict;
    crc_v          = crc;
    nhz_v          = nhz;
    r0             = 1'b0;
    r1             = 1'b0;
    r0_facts       = 1'b0;
    r0_status      = ST_OK;
    k              = (fbc >= HEADER_LEN) ? K_FIRST : fbc;
    sig            = {data_byte, sig_lo};

    if (step) begin
      pos_next = pos + 1'b1;
      unique case (phase)
        PH_HEADER: begin
          if (k == K_FIRST) begin
            nhz_next     = 1'b0;
            crc_next     = ALL_ONES;
            verdict_next = ST_OK;
          end
          unique case (k)
            5'd0:    sig_lo_next[7:0]    = data_byte;
            5'd1:    sig_lo_next[15:8]   = data_byte;
            5'd2:    sig_lo_next[23:16]  = data_byte;
            5'd6:    desc_flag_next      = data_byte[3];
            5'd8:    method_next[7:0]    = data_byte;
            5'd9:    method_next[15:8]   = data_byte;
            5'd14:   hcrc_next[7:0]      = data_byte;
            5'd15:   hcrc_next[15:8]     = data_byte;
            5'd16:   hcrc_next[23:16]    = data_byte;
            5'd17:   hcrc_next[31:24]    = data_byte;
            5'd18:   comp_next[7:0]      = data_byte;
            5'd19:   comp_next[15:8]     = data_byte;
            5'd20:   comp_next[23:16]    = data_byte;
            5'd21:   comp_next[31:24]    = data_byte;
            5'd22:   uncomp_next[7:0]    = data_byte;
            5'd23:   uncomp_next[15:8]   = data_byte;
            5'd24:   uncomp_next[23:16]  = data_byte;
            5'd25:   uncomp_next[31:24]  = data_byte;
            5'd26:   nlen_next[7:0]      = data_byte;
            5'd27:   nlen_next[15:8]     = data_byte;
            5'd28:   xlen_next[7:0]      = data_byte;
            5'd29:   xlen_next[15:8]     = data_byte;
            default: ;
          endcase
          if (k == K_SIG) begin
            if (sig == SIG_CENTRAL || sig == SIG_END) begin
              r0         = 1'b1;
              r0_status  = ST_END;
              phase_next = PH_DONE;
            end else if (sig != SIG_LOCAL) begin
              r0         = 1'b1;
              r0_status  = ST_MALFORMED;
              phase_next = PH_DONE;
            end else begin
              fbc_next = k + 5'd1;
            end
          end else if (k == K_LAST) begin
            if (desc_flag) begin
              verdict_v = ST_MALFORMED;
            end else if (method != METHOD_STORED && method != METHOD_DEFLATE) begin
              verdict_v = ST_UNSUPPORTED;
            end else if (method == METHOD_STORED && comp != uncomp) begin
              verdict_v = ST_MALFORMED;
            end else begin
              verdict_v = ST_OK;
            end
            verdict_next = verdict_v;
            fbc_next     = K_FIRST;
            xlen_v       = {data_byte, xlen[7:0]};
            adv          = 1'b1;
            adv_name     = 1'b1;
            adv_extra    = 1'b1;
          end else begin
            fbc_next = k + 5'd1;
          end
        end
        PH_NAME: begin
          nhz_v     = nhz | (data_byte == 8'd0);
          nhz_next  = nhz_v;
          left_next = left - 32'd1;
          if (left == 32'd1) begin
            adv       = 1'b1;
            adv_extra = 1'b1;
          end
        end
        PH_EXTRA: begin
          left_next = left - 32'd1;
          if (left == 32'd1) adv = 1'b1;
        end
        PH_PAYLOAD: begin
          crc_v     = crc_upd;
          crc_next  = crc_upd;
          left_next = left - 32'd1;
          if (left == 32'd1) fin = 1'b1;
        end
        PH_DONE: ;
        default: ;
      endcase

      if (adv) begin
        priority if (adv_name && nlen != 16'd0) begin
          phase_next = PH_NAME;
          left_next  = {16'd0, nlen};
        end else if (adv_extra && xlen_v != 16'd0) begin
          phase_next = PH_EXTRA;
          left_next  = {16'd0, xlen_v};
        end else if (comp != 32'd0) begin
          phase_next = PH_PAYLOAD;
          left_next  = comp;
        end else begin
          fin = 1'b1;
        end
      end

      if (fin) begin
        fin_status = verdict_v;
        if (verdict_v == ST_OK && method == METHOD_STORED && ~crc_v != hcrc) begin
          fin_status = ST_CRC;
        end
        r0        = 1'b1;
        r0_status = fin_status;
        if (fin_status == ST_OK) begin
          r0_facts   = 1'b1;
          phase_next = PH_HEADER;
          fbc_next   = K_FIRST;
          r1         = last_byte;
        end else begin
          phase_next = PH_DONE;
        end
      end

      if (last_byte && !r0 && phase_next != PH_DONE) begin
        r0        = 1'b1;
        r0_status = ST_MALFORMED;
      end

      if (last_byte) begin
        phase_next   = PH_HEADER;
        pos_next     = '0;
        fbc_next     = K_FIRST;
        left_next    = 32'd0;
        crc_next     = ALL_ONES;
        nhz_next     = 1'b0;
        verdict_next = ST_OK;
      end
    end
  end

  assign offset = pos + 1'b1 - comp[POS_BITS-1:0];

  always_comb begin
    push.count  = r1 ? 2'd2 : (r0 ? 2'd1 : 2'd0);
    push.first  = '0;
    push.second = '0;
    push.first.status       = r0_status;
    push.first.final_result = !r1;
    if (r0_facts) begin
      push.first.payload_offset    = 32'(offset);
      push.first.payload_size      = comp;
      push.first.uncompressed_size = uncomp;
      push.first.is_deflated       = (method == METHOD_DEFLATE);
      push.first.header_crc        = hcrc;
      push.first.name_len          = nlen;
      push.first.name_usable       = (nlen < limit) && !nhz_v;
    end
    push.second.status       = ST_END;
    push.second.final_result = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HEADER;
      pos     <= '0;
      fbc     <= K_FIRST;
      left    <= 32'd0;
      crc     <= ALL_ONES;
      nhz     <= 1'b0;
      verdict <= ST_OK;
    end else begin
      phase   <= phase_next;
      pos     <= pos_next;
      fbc     <= fbc_next;
      left    <= left_next;
      crc     <= crc_next;
      nhz     <= nhz_next;
      verdict <= verdict_next;
    end
  end

  always_ff @(posedge clk) begin
    sig_lo    <= sig_lo_next;
    desc_flag <= desc_flag_next;
    method    <= method_next;
    hcrc      <= hcrc_next;
    comp      <= comp_next;
    uncomp    <= uncomp_next;
    nlen      <= nlen_next;
    xlen      <= xlen_next;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/zlhw_result_fifo.sv =====
// zlhw_result_fifo: small result queue, up to two pushes and one pop a cycle
// depends on zlhw_pkg for result_t, walk_push_t and queue sizing
`default_nettype none

module zlhw_result_fifo import zlhw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  walk_push_t               push,
  input  logic                     pop,
  output result_t                  head,
  output logic [FIFO_CNT_BITS-1:0] fill
);

  result_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr, wr_next, rd, rd_next;
  logic [FIFO_CNT_BITS-1:0] fill_next;

  always_comb begin
    wr_next   = wr + FIFO_PTR_BITS'(push.count);
    rd_next   = rd + FIFO_PTR_BITS'(pop);
    fill_next = fill + FIFO_CNT_BITS'(push.count) - FIFO_CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr   <= '0;
      rd   <= '0;
      fill <= '0;
    end else begin
      wr   <= wr_next;
      rd   <= rd_next;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr] <= push.first;
    if (push.count == 2'd2) mem[wr + FIFO_PTR_BITS'(1)] <= push.second;
  end

  assign head = mem[rd];

endmodule

`default_nettype wire

// ===== hw/rtl/zip_local_header_walker.sv =====
// zip_local_header_walker: top level, input stage, config register, result queue
// depends on zlhw_pkg, zlhw_walker, zlhw_result_fifo
//
//   channel   signals                                  direction
//   input     in_valid/in_ready, data_byte, last_byte  in
//   result    out_valid/out_ready, status .. final      out
//   config    cfg_valid/cfg_ready, name_limit          in
//
// one archive byte per cycle sustained while the result queue has room; a
// result is offered once its byte has passed the input stage and the walker
// has stepped it into the result queue
// the walker steps only with two free queue entries, otherwise in_ready drops
// synchronous reset, no clearing pass; name_limit resets to 32
// the config register is always ready
`default_nettype none

module zip_local_header_walker import zlhw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] payload_offset,
  output logic [31:0] payload_size,
  output logic [31:0] uncompressed_size,
  output logic        is_deflated,
  output logic [31:0] header_crc,
  output logic [15:0] name_len,
  output logic        name_usable,
  output logic        final_result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] name_limit
);

  logic                     stage_valid;
  logic [7:0]               stage_byte;
  logic                     stage_last;
  logic                     step;
  logic [15:0]              limit;
  walk_push_t               push;
  result_t                  head;
  logic [FIFO_CNT_BITS-1:0] fill;

  assign step      = stage_valid && (fill <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
  assign in_ready  = !stage_valid || step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      limit       <= NAME_LIMIT_RESET;
    end else begin
      if (in_ready) stage_valid <= in_valid;
      if (cfg_valid) limit <= name_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte <= data_byte;
      stage_last <= last_byte;
    end
  end

  zlhw_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (stage_byte),
    .last_byte (stage_last),
    .limit     (limit),
    .push      (push)
  );

  zlhw_result_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (out_valid && out_ready),
    .head (head),
    .fill (fill)
  );

  assign out_valid         = (fill != '0);
  assign status            = head.status;
  assign payload_offset    = head.payload_offset;
  assign payload_size      = head.payload_size;
  assign uncompressed_size = head.uncompressed_size;
  assign is_deflated       = head.is_deflated;
  assign header_crc        = head.header_crc;
  assign name_len          = head.name_len;
  assign name_usable       = head.name_usable;
  assign final_result      = head.final_result;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FIFO_CNT_BITS'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_non_final_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !final_result) |-> (status == ST_OK))
    else $error("non-final result is not ok");

  a_error_no_facts: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |->
      (payload_size == 32'd0 && header_crc == 32'd0 && name_len == 16'd0))
    else $error("facts on a non-ok result");

  a_step_space: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |=> (fill != '0))
    else $error("pushed result lost");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/zip_local_header_walker_tb.sv =====
// zip_local_header_walker_tb: self-checking bench for the zip local header walker
// builds archives byte by byte, predicts every verdict and compares each result transfer
// depends on zlhw_pkg and zip_local_header_walker
module zip_local_header_walker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import zlhw_pkg::*;

  localparam logic [15:0] FLAG_DATA_DESCRIPTOR = 16'h0008;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SEGMENT_BYTES = 475;

  typedef enum logic [2:0] {
    WALK_HEADER, WALK_NAME, WALK_EXTRA, WALK_PAYLOAD, WALK_DONE
  } walk_phase_t;

  typedef enum int {
    TAIL_BOUNDARY, TAIL_CENTRAL, TAIL_END_RECORD, TAIL_CUT, TAIL_BAD_SIG, TAIL_PART_SIG
  } archive_tail_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } archive_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [31:0] payload_offset;
  logic [31:0] payload_size;
  logic [31:0] uncompressed_size;
  logic        is_deflated;
  logic [31:0] header_crc;
  logic [15:0] name_len;
  logic        name_usable;
  logic        final_result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] name_limit = NAME_LIMIT_RESET;

  zip_local_header_walker DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  archive_byte_t archive_stream[$];
  logic [7:0]    build_buf[$];
  logic [7:0]    payload_buf[$];
  result_t       verdicts_due[$];
  result_t       step_verdicts[2];
  result_t       oldest;
  int            step_n;
  int            items_queued = 0;
  int            errors = 0;
  int            send_idle_pct = 35;
  int            recv_idle_pct = 72;
  int            idle_cycles = 0;
  int            hold_left = 0;
  bit            hold_req = 1'b0;
  bit            hold_done = 1'b0;

  // walker state as predicted
  walk_phase_t w_phase;
  logic [31:0] w_pos;
  logic [4:0]  w_count;
  logic [63:0] w_fields[3];
  logic [31:0] w_left;
  logic [31:0] w_crc;
  bit          w_zero;
  status_t     w_verdict;
  logic [15:0] limit_now;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  task automatic restart_walk();
    w_phase = WALK_HEADER;
    w_pos = '0;
    w_count = '0;
    for (int i = 0; i < 3; i++) w_fields[i] = '0;
    w_left = '0;
    w_crc = ALL_ONES;
    w_zero = 1'b0;
    w_verdict = ST_OK;
  endtask

  task automatic emit_result(input status_t st, input bit facts, input logic [31:0] pos);
    result_t r;
    r = '0;
    r.status = st;
    if (facts) begin
      r.payload_offset = pos + 32'd1 - w_fields[1][31:0];
      r.payload_size = w_fields[1][31:0];
      r.uncompressed_size = w_fields[1][63:32];
      r.is_deflated = (w_fields[0][31:16] == METHOD_DEFLATE);
      r.header_crc = w_fields[0][63:32];
      r.name_len = w_fields[2][15:0];
      r.name_usable = (w_fields[2][15:0] < limit_now) && !w_zero;
    end
    step_verdicts[step_n] = r;
    step_n = step_n + 1;
  endtask

  task automatic finish_member(input logic [31:0] pos, input bit last);
    status_t st;
    st = w_verdict;
    if (st == ST_OK && w_fields[0][31:16] == METHOD_STORED &&
        (w_crc ^ ALL_ONES) != w_fields[0][63:32]) st = ST_CRC;
    if (st == ST_OK) begin
      emit_result(ST_OK, 1'b1, pos);
      w_phase = WALK_HEADER;
      w_count = '0;
      if (last) emit_result(ST_END, 1'b0, pos);
    end else begin
      emit_result(st, 1'b0, pos);
      w_phase = WALK_DONE;
    end
  endtask

  task automatic advance(input walk_phase_t from, input logic [31:0] pos, input bit last);
    if (from <= WALK_NAME && w_fields[2][15:0] != 0) begin
      w_phase = WALK_NAME;
      w_left = {16'd0, w_fields[2][15:0]};
    end else if (from <= WALK_EXTRA && w_fields[2][31:16] != 0) begin
      w_phase = WALK_EXTRA;
      w_left = {16'd0, w_fields[2][31:16]};
    end else if (from <= WALK_PAYLOAD && w_fields[1][31:0] != 0) begin
      w_phase = WALK_PAYLOAD;
      w_left = w_fields[1][31:0];
    end else begin
      finish_member(pos, last);
    end
  endtask

  task automatic walk_byte(input logic [7:0] b, input bit last);
    logic [31:0] pos;
    logic [31:0] sig;
    logic [4:0]  k;
    logic [5:0]  sh;
    int          slot;
    pos = w_pos;
    w_pos = pos + 32'd1;
    step_n = 0;
    case (w_phase)
      WALK_HEADER: begin
        if (w_count >= HEADER_LEN) w_count = '0;
        k = w_count;
        if (k == 0) begin
          for (int i = 0; i < 3; i++) w_fields[i] = '0;
          w_zero = 1'b0;
          w_crc = ALL_ONES;
          w_verdict = ST_OK;
        end
        slot = 3;
        sh = '0;
        if (k <= 3) begin
          slot = 1;
          sh = 6'(8 * k);
        end else if (k >= 6 && k <= 9) begin
          slot = 0;
          sh = 6'(8 * (k - 6));
        end else if (k >= 14 && k <= 17) begin
          slot = 0;
          sh = 6'(32 + 8 * (k - 14));
        end else if (k >= 18 && k <= 25) begin
          slot = 1;
          sh = 6'(8 * (k - 18));
        end else if (k >= 26) begin
          slot = 2;
          sh = 6'(8 * (k - 26));
        end
        if (slot != 3) w_fields[slot] = w_fields[slot] | ({56'd0, b} << sh);
        if (k == 3) begin
          sig = w_fields[1][31:0];
          if (sig == SIG_CENTRAL || sig == SIG_END) begin
            emit_result(ST_END, 1'b0, pos);
            w_phase = WALK_DONE;
          end else if (sig != SIG_LOCAL) begin
            emit_result(ST_MALFORMED, 1'b0, pos);
            w_phase = WALK_DONE;
          end else begin
            w_fields[1] = '0;
            w_count = 5'd4;
          end
        end else if (k == HEADER_LEN - 1) begin
          if ((w_fields[0][15:0] & FLAG_DATA_DESCRIPTOR) != 0) w_verdict = ST_MALFORMED;
          else if (w_fields[0][31:16] != METHOD_STORED && w_fields[0][31:16] != METHOD_DEFLATE)
            w_verdict = ST_UNSUPPORTED;
          else if (w_fields[0][31:16] == METHOD_STORED &&
                   w_fields[1][31:0] != w_fields[1][63:32]) w_verdict = ST_MALFORMED;
          else w_verdict = ST_OK;
          w_count = '0;
          advance(WALK_NAME, pos, last);
        end else begin
          w_count = k + 5'd1;
        end
      end
      WALK_NAME: begin
        if (b == 8'h00) w_zero = 1'b1;
        w_left = w_left - 32'd1;
        if (w_left == 0) advance(WALK_EXTRA, pos, last);
      end
      WALK_EXTRA: begin
        w_left = w_left - 32'd1;
        if (w_left == 0) advance(WALK_PAYLOAD, pos, last);
      end
      WALK_PAYLOAD: begin
        w_crc = crc_byte(w_crc, b);
        w_left = w_left - 32'd1;
        if (w_left == 0) finish_member(pos, last);
      end
      default: ;
    endcase
    if (last && step_n == 0 && w_phase != WALK_DONE) emit_result(ST_MALFORMED, 1'b0, pos);
    if (step_n > 0) step_verdicts[step_n - 1].final_result = 1'b1;
    for (int i = 0; i < step_n; i++) verdicts_due.push_back(step_verdicts[i]);
    if (last) restart_walk();
  endtask

  task automatic compare_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      errors = errors + 1;
    end
  endtask

  // archive construction
  task automatic put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) build_buf.push_back(v[8*i +: 8]);
  endtask

  task automatic add_member(input logic [15:0] flags, input logic [15:0] method, input int nlen,
                            input int xlen, input int psize, input bit bad_crc, input bit skew);
    logic [31:0] crc_acc;
    logic [31:0] crc_field;
    logic [31:0] uncomp;
    logic [7:0]  b;
    crc_acc = ALL_ONES;
    payload_buf.delete();
    for (int i = 0; i < psize; i++) begin
      b = 8'($urandom);
      payload_buf.push_back(b);
      crc_acc = crc_byte(crc_acc, b);
    end
    crc_acc = crc_acc ^ ALL_ONES;
    if (method == METHOD_STORED) begin
      crc_field = bad_crc ? (crc_acc ^ (32'd1 << $urandom_range(31))) : crc_acc;
      uncomp = psize + (skew ? 1 : 0);
    end else begin
      crc_field = ($urandom_range(3) == 0) ? ALL_ONES : $urandom;
      uncomp = ($urandom_range(3) == 0) ? ALL_ONES : $urandom;
    end
    put_le(SIG_LOCAL, 4);
    put_le($urandom, 2);
    put_le(32'(flags), 2);
    put_le(32'(method), 2);
    put_le($urandom, 4);
    put_le(crc_field, 4);
    put_le(psize, 4);
    put_le(uncomp, 4);
    put_le(nlen, 2);
    put_le(xlen, 2);
    for (int i = 0; i < nlen; i++)
      build_buf.push_back(($urandom_range(11) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
    for (int i = 0; i < xlen; i++) build_buf.push_back(8'($urandom));
    foreach (payload_buf[i]) build_buf.push_back(payload_buf[i]);
  endtask

  task automatic ship_archive();
    archive_byte_t item;
    if (build_buf.size() == 0) build_buf.push_back(8'($urandom));
    foreach (build_buf[i]) begin
      item.data = build_buf[i];
      item.last = (i == build_buf.size() - 1);
      archive_stream.push_back(item);
    end
    items_queued = items_queued + build_buf.size();
    build_buf.delete();
  endtask

  task automatic close_archive(input archive_tail_t tail_kind);
    int cut;
    case (tail_kind)
      TAIL_CENTRAL: begin
        put_le(SIG_CENTRAL, 4);
        put_le($urandom, $urandom_range(0, 4));
      end
      TAIL_END_RECORD: begin
        put_le(SIG_END, 4);
        put_le($urandom, $urandom_range(0, 4));
      end
      TAIL_CUT: begin
        if (build_buf.size() > 1) begin
          cut = $urandom_range(1, build_buf.size() - 1);
          while (build_buf.size() > cut) void'(build_buf.pop_back());
        end
      end
      TAIL_BAD_SIG: begin
        put_le($urandom, 4);
        put_le($urandom, $urandom_range(0, 4));
      end
      TAIL_PART_SIG: put_le(SIG_LOCAL, $urandom_range(1, 3));
      default: ;
    endcase
    ship_archive();
  endtask

  task automatic random_archive();
    int          members;
    int          r;
    int          nlen;
    logic [15:0] flags;
    logic [15:0] method;
    members = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 3);
    repeat (members) begin
      flags = 16'($urandom) & ~FLAG_DATA_DESCRIPTOR;
      if ($urandom_range(11) == 0) flags = flags | FLAG_DATA_DESCRIPTOR;
      r = $urandom_range(99);
      method = (r < 55) ? METHOD_STORED : (r < 90) ? METHOD_DEFLATE : 16'($urandom);
      nlen = ($urandom_range(9) == 0) ? $urandom_range(25, 40) : $urandom_range(0, 6);
      add_member(flags, method, nlen, $urandom_range(0, 3), $urandom_range(0, 8),
                 $urandom_range(7) == 0, $urandom_range(11) == 0);
    end
    r = $urandom_range(9);
    close_archive(r < 3 ? TAIL_BOUNDARY : r < 5 ? TAIL_CENTRAL : r == 5 ? TAIL_END_RECORD :
                  r < 8 ? TAIL_CUT : r == 8 ? TAIL_BAD_SIG : TAIL_PART_SIG);
  endtask

  task automatic random_segment();
    int target;
    @(negedge clk);
    target = items_queued + SEGMENT_BYTES;
    while (items_queued < target) random_archive();
  endtask

  task automatic write_limit(input logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    name_limit <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (archive_stream.size() != 0 || in_valid || verdicts_due.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (archive_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        data_byte <= archive_stream[0].data;
        last_byte <= archive_stream[0].last;
        void'(archive_stream.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= LONG_HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // prediction on each byte transfer, checking on each result transfer
  always @(posedge clk) begin
    if (rst) begin
      restart_walk();
      limit_now = NAME_LIMIT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) limit_now = name_limit;
      if (in_valid && in_ready) walk_byte(data_byte, last_byte);
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected result, status %0d", $time, status);
          errors = errors + 1;
        end else begin
          oldest = verdicts_due.pop_front();
          compare_field("status", 32'(oldest.status), 32'(status));
          compare_field("payload_offset", oldest.payload_offset, payload_offset);
          compare_field("payload_size", oldest.payload_size, payload_size);
          compare_field("uncompressed_size", oldest.uncompressed_size, uncompressed_size);
          compare_field("is_deflated", 32'(oldest.is_deflated), 32'(is_deflated));
          compare_field("header_crc", oldest.header_crc, header_crc);
          compare_field("name_len", 32'(oldest.name_len), 32'(name_len));
          compare_field("name_usable", 32'(oldest.name_usable), 32'(name_usable));
          compare_field("final_result", 32'(oldest.final_result), 32'(final_result));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("zip_local_header_walker: mismatch");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // truncated inside a signature, then central, end record with ignored tail
    build_buf.push_back(8'hFF);
    ship_archive();
    put_le(SIG_CENTRAL, 4);
    ship_archive();
    put_le(SIG_END, 4);
    put_le(32'h0, 1);
    ship_archive();
    // unknown signature, partial signature
    put_le(32'h0, 4);
    ship_archive();
    put_le(SIG_LOCAL, 2);
    ship_archive();
    // one stored member ending on the last byte
    add_member(16'h0000, METHOD_STORED, 2, 1, 1, 1'b0, 1'b0);
    ship_archive();
    wait_drained();

    write_limit(16'd1);
    random_segment();
    wait_drained();

    send_idle_pct = 72;
    recv_idle_pct = 35;
    write_limit(16'hFFFF);
    random_segment();
    wait_drained();
    write_limit(16'($urandom_range(2, 64)));
    random_segment();
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(16'd20);
    hold_req = 1'b1;
    random_segment();
    wait_drained();

    if (errors == 0) $display("zip_local_header_walker: match");
    else $display("zip_local_header_walker: mismatch");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/zlhw_pkg.sv
hw/rtl/zlhw_crc_byte.sv
hw/rtl/zlhw_walker.sv
hw/rtl/zlhw_result_fifo.sv
hw/rtl/zip_local_header_walker.sv
tb/sv/zip_local_header_walker_tb.sv
